FILE: hdl/life_pkg.sv
// Shared types and constants for the life grid generation engine.
// Used by life_ctrl, life_dpath, life_row_eval and the top level; no dependencies.
`default_nettype none

package life_pkg;

    // default grid bounds
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // field widths
    localparam int ACT_W      = 2;
    localparam int ROW_IN_W   = 6;
    localparam int COL_IN_W   = 6;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 4;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // config register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0]     ACTIVE_RST      = CFG_W'(64);

    // B3/S23 neighbor counts
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE   = 2'd0,
        ACT_CLEAR   = 2'd1,
        ACT_ADVANCE = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    // grid read address source
    typedef enum logic [1:0] {
        RA_REQ  = 2'd0,   // requested row
        RA_CUR  = 2'd1,   // cursor
        RA_CUR1 = 2'd2,   // cursor + 1
        RA_CUR2 = 2'd3    // cursor + 2
    } rd_sel_t;

    // grid write data source
    typedef enum logic [1:0] {
        WS_ZERO  = 2'd0,  // clear sweep, at cursor
        WS_CELL  = 2'd1,  // single-cell update, at requested row
        WS_FRESH = 2'd2   // next generation row, at cursor
    } wr_sel_t;

    typedef struct packed {
        logic    latch_in;
        logic    cur_inc;
        logic    mem_rd;
        rd_sel_t rd_sel;
        logic    mem_wr;
        wr_sel_t wr_sel;
        logic    above_clr;
        logic    row_load;
        logic    row_shift;
        logic    res_load;
        logic    res_cell;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic in_range;
        logic is_write;
        logic rows_zero;
        logic sweep_last;
        logic clr_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/life_row_eval.sv
// Next-generation evaluation of one grid row under B3/S23.
// Depends on life_pkg for the rule counts.
`default_nettype none

module life_row_eval
    import life_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic [MAX_COLS-1:0] col_mask,
    input  wire logic [MAX_COLS-1:0] above,
    input  wire logic [MAX_COLS-1:0] cur,
    input  wire logic [MAX_COLS-1:0] below,
    output logic      [MAX_COLS-1:0] fresh
);

    logic [MAX_COLS-1:0] a, m, b;
    logic [MAX_COLS-1:0] a_l, a_r, m_l, m_r, b_l, b_r;

    // inactive columns read as dead
    assign a = above & col_mask;
    assign m = cur   & col_mask;
    assign b = below & col_mask;

    // bit c of *_l holds column c-1, bit c of *_r holds column c+1
    assign a_l = a << 1;
    assign a_r = a >> 1;
    assign m_l = m << 1;
    assign m_r = m >> 1;
    assign b_l = b << 1;
    assign b_r = b >> 1;

    always_comb begin
        logic [3:0] n;
        for (int c = 0; c < MAX_COLS; c++) begin
            n = 4'(a_l[c]) + 4'(a[c]) + 4'(a_r[c]) + 4'(m_l[c]) + 4'(m_r[c])
              + 4'(b_l[c]) + 4'(b[c]) + 4'(b_r[c]);
            fresh[c] = col_mask[c] &
                       ((n == BIRTH_COUNT) || (m[c] && (n == SURVIVE_COUNT)));
        end
    end

endmodule

`default_nettype wire

FILE: hdl/life_dpath.sv
// Datapath: grid memory, config registers, sweep cursor, row registers, result
// and output registers. Depends on life_pkg and life_row_eval.
`default_nettype none

module life_dpath
    import life_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic [ACT_W-1:0]      in_action,
    input  wire logic [ROW_IN_W-1:0]   in_row,
    input  wire logic [COL_IN_W-1:0]   in_col,
    input  wire logic                  in_value,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic                       m_cell_state,
    output logic                       m_range_error
);

    localparam int AW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int CUR_B = $clog2(MAX_ROWS + 2);
    localparam int CNT_W = (CUR_B > CFG_W) ? CUR_B : CFG_W;

    // config
    logic [CFG_W-1:0] active_rows_reg, active_cols_reg;

    // latched request
    action_t             act_reg;
    logic [ROW_IN_W-1:0] row_reg;
    logic [COL_IN_W-1:0] col_reg;
    logic                value_reg;

    // sweep state
    logic [CNT_W-1:0]    cursor_reg, cursor_next;
    logic [MAX_COLS-1:0] above_reg, cur_reg;

    // grid memory
    logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] rd_data_reg;
    logic [CNT_W-1:0]    rd_addr_full, wr_addr_full;
    logic                rd_en;
    logic [MAX_COLS-1:0] wr_data;

    // result and output
    logic res_state_reg, res_err_reg;
    logic m_tvalid_reg, m_state_reg, m_err_reg;

    logic [CNT_W-1:0]    nr, rows_ext, cur_p1, cur_p2;
    logic [CFG_W-1:0]    nc, cols_max;
    logic [MAX_COLS-1:0] col_mask, below, fresh, cell_row;
    logic [CW-1:0]       col_idx;
    logic                in_range, cell_bit;

    // effective size: register clamped to the grid bounds
    assign rows_ext = CNT_W'(active_rows_reg);
    assign nr       = (rows_ext > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_ext;
    assign cols_max = CFG_W'(MAX_COLS);
    assign nc       = (active_cols_reg > cols_max) ? cols_max : active_cols_reg;

    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            col_mask[c] = (CFG_W'(c) < nc);
        end
    end

    assign cur_p1   = cursor_reg + CNT_W'(1);
    assign cur_p2   = cursor_reg + CNT_W'(2);
    assign in_range = (CNT_W'(row_reg) < nr) && (CFG_W'(col_reg) < nc);
    assign col_idx  = col_reg[CW-1:0];
    assign cell_bit = rd_data_reg[col_idx];

    always_comb begin
        cell_row          = rd_data_reg;
        cell_row[col_idx] = value_reg;
    end

    // last row of the sweep has no row below
    assign below = (cur_p1 < nr) ? rd_data_reg : '0;

    life_row_eval #(
        .MAX_COLS (MAX_COLS)
    ) u_row_eval (
        .col_mask (col_mask),
        .above    (above_reg),
        .cur      (cur_reg),
        .below    (below),
        .fresh    (fresh)
    );

    always_comb begin
        case (cmd.rd_sel)
            RA_REQ:  rd_addr_full = CNT_W'(row_reg);
            RA_CUR:  rd_addr_full = cursor_reg;
            RA_CUR1: rd_addr_full = cur_p1;
            RA_CUR2: rd_addr_full = cur_p2;
            default: rd_addr_full = cursor_reg;
        endcase
    end
    assign rd_en = cmd.mem_rd && (rd_addr_full < CNT_W'(MAX_ROWS));

    always_comb begin
        case (cmd.wr_sel)
            WS_ZERO: begin
                wr_addr_full = cursor_reg;
                wr_data      = '0;
            end
            WS_CELL: begin
                wr_addr_full = CNT_W'(row_reg);
                wr_data      = cell_row;
            end
            WS_FRESH: begin
                wr_addr_full = cursor_reg;
                wr_data      = (cur_reg & ~col_mask) | fresh;
            end
            default: begin
                wr_addr_full = cursor_reg;
                wr_data      = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            grid_mem[wr_addr_full[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= grid_mem[rd_addr_full[AW-1:0]];
        end
    end

    always_comb begin
        cursor_next = cursor_reg;
        if (cmd.latch_in) begin
            cursor_next = '0;
        end else if (cmd.cur_inc) begin
            cursor_next = cur_p1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg      <= '0;
            active_rows_reg <= ACTIVE_RST;
            active_cols_reg <= ACTIVE_RST;
            m_tvalid_reg    <= 1'b0;
        end else begin
            cursor_reg <= cursor_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_ACTIVE_ROWS: active_rows_reg <= cfg_data;
                    REG_ACTIVE_COLS: active_cols_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            act_reg   <= action_t'(in_action);
            row_reg   <= in_row;
            col_reg   <= in_col;
            value_reg <= in_value;
        end
        if (cmd.above_clr) begin
            above_reg <= '0;
        end else if (cmd.row_shift) begin
            above_reg <= cur_reg;
        end
        if (cmd.row_load || cmd.row_shift) begin
            cur_reg <= rd_data_reg;
        end
        if (cmd.res_load) begin
            res_err_reg   <= cmd.res_cell && !in_range;
            res_state_reg <= cmd.res_cell && in_range && (act_reg == ACT_READ) && cell_bit;
        end
        if (cmd.out_load) begin
            m_state_reg <= res_state_reg;
            m_err_reg   <= res_err_reg;
        end
    end

    assign status.in_range   = in_range;
    assign status.is_write   = (act_reg == ACT_WRITE);
    assign status.rows_zero  = (nr == '0);
    assign status.sweep_last = (cur_p1 == nr);
    assign status.clr_last   = (cursor_reg == CNT_W'(MAX_ROWS - 1));
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid      = m_tvalid_reg;
    assign m_cell_state  = m_state_reg;
    assign m_range_error = m_err_reg;

endmodule

`default_nettype wire

FILE: hdl/life_ctrl.sv
// Controller state machine: sequences clear sweeps, cell accesses and
// generation sweeps. Depends on life_pkg for command and status types.
`default_nettype none

module life_ctrl
    import life_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [ACT_W-1:0] s_action,
    input  wire dp_status_t       status,
    output dp_cmd_t               cmd
);

    typedef enum logic [8:0] {
        ST_INIT      = 9'b000000001,
        ST_IDLE      = 9'b000000010,
        ST_CLEAR     = 9'b000000100,
        ST_CELL_CHK  = 9'b000001000,
        ST_CELL_DO   = 9'b000010000,
        ST_ADV_START = 9'b000100000,
        ST_ADV_PRIME = 9'b001000000,
        ST_ADV_SWEEP = 9'b010000000,
        ST_RESP      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_sel  = WS_ZERO;
                cmd.cur_inc = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    case (action_t'(s_action))
                        ACT_WRITE, ACT_READ: state_next = ST_CELL_CHK;
                        ACT_CLEAR:           state_next = ST_CLEAR;
                        ACT_ADVANCE:         state_next = ST_ADV_START;
                        default:             state_next = ST_CELL_CHK;
                    endcase
                end
            end
            ST_CLEAR: begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_sel  = WS_ZERO;
                cmd.cur_inc = 1'b1;
                if (status.clr_last) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_RESP;
                end
            end
            ST_CELL_CHK: begin
                if (status.in_range) begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RA_REQ;
                    state_next = ST_CELL_DO;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res_cell = 1'b1;
                    state_next   = ST_RESP;
                end
            end
            ST_CELL_DO: begin
                cmd.mem_wr   = status.is_write;
                cmd.wr_sel   = WS_CELL;
                cmd.res_load = 1'b1;
                cmd.res_cell = 1'b1;
                state_next   = ST_RESP;
            end
            ST_ADV_START: begin
                if (status.rows_zero) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_RESP;
                end else begin
                    cmd.mem_rd    = 1'b1;
                    cmd.rd_sel    = RA_CUR;
                    cmd.above_clr = 1'b1;
                    state_next    = ST_ADV_PRIME;
                end
            end
            ST_ADV_PRIME: begin
                cmd.mem_rd   = 1'b1;
                cmd.rd_sel   = RA_CUR1;
                cmd.row_load = 1'b1;
                state_next   = ST_ADV_SWEEP;
            end
            ST_ADV_SWEEP: begin
                cmd.mem_wr    = 1'b1;
                cmd.wr_sel    = WS_FRESH;
                cmd.mem_rd    = 1'b1;
                cmd.rd_sel    = RA_CUR2;
                cmd.row_shift = 1'b1;
                cmd.cur_inc   = 1'b1;
                if (status.sweep_last) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_RESP;
                end
            end
            ST_RESP: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/life_grid_generation_engine.sv
// Top level of the life grid generation engine (rule B3/S23).
// Depends on life_pkg, life_ctrl and life_dpath.
//
// Holds a grid of up to MAX_ROWS x MAX_COLS cells, one memory row per grid
// row, and serves one request at a time: write a cell, clear the grid,
// advance one generation, or read a cell. Every request returns exactly one
// result carrying cell_state and range_error. Cells outside the active size
// count as dead and are not updated by an advance. A cell write or read
// checks the range, reads the row, then writes it back (for a write only)
// and loads the result (an out-of-range access skips the read and write); a
// clear zeroes all MAX_ROWS rows; an advance reads the first two rows, then
// runs a sweep that evaluates one whole row per cycle against the
// single-read, single-write grid memory (with no rows active it skips the
// sweep). The next request can be taken in the cycle after the result is
// loaded into the output register. After reset the grid is cleared by a pass
// over all MAX_ROWS rows, during which s_tready stays low; configuration
// writes are taken at any time with cfg_ready held high. A finished result
// waits in the output register while the next request is accepted.
`default_nettype none

module life_grid_generation_engine
    import life_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,   // 3 .. 1024
    parameter int MAX_COLS = MAX_COLS_DEF    // 3 .. 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // row[5:0], col[11:6], value[12]
    input  wire logic [ACT_W-1:0]      s_tuser,   // action[1:0]
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // cell_state[0], range_error[1]
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       m_cell_state, m_range_error;

    // config writes never stall
    assign cfg_ready = 1'b1;

    life_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    life_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_action     (s_tuser),
        .in_row        (s_tdata[ROW_IN_W-1:0]),
        .in_col        (s_tdata[ROW_IN_W+COL_IN_W-1:ROW_IN_W]),
        .in_value      (s_tdata[ROW_IN_W+COL_IN_W]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_cell_state  (m_cell_state),
        .m_range_error (m_range_error)
    );

    assign m_tdata = {{(OUT_DATA_W-2){1'b0}}, m_range_error, m_cell_state};

endmodule

`default_nettype wire
